// File: rtl/wltp_pkg.sv
// Shared types and constants for the windowed linear trend predictor.
// No dependencies; used by wltp_div and windowed_linear_trend_predictor_top.
package wltp_pkg;

   localparam int OUT_W       = 40;  // width of prediction, slope and intercept
   localparam int SLOPE_FRAC  = 16;
   localparam int VALUE_FRAC  = 8;
   localparam int WIDE_SHIFT  = SLOPE_FRAC + 1;  // one extra bit feeds rounding
   localparam int NARROW_SHIFT = VALUE_FRAC + 1;

   localparam logic [6:0] WL_RESET = 7'd16;
   localparam logic [7:0] HZ_RESET = 8'd1;

   typedef enum logic [0:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_HORIZON       = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_DIV_M,
      ST_DIV_B,
      ST_DIV_P,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic wide_frac;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// File: rtl/windowed_linear_trend_predictor_top.sv
// Windowed linear trend predictor, top level.
// Depends on wltp_pkg and wltp_div.
//
// Usage:
//  - req_ channel: one signed sample per beat, appended to a ring of the last
//    MAX_WINDOW samples. rsp_ channel: one result beat per request beat with
//    prediction (Q.8), slope (Q.16), intercept (Q.8) and fit_ok.
//  - csr_ port: index 0 writes window_length, index 1 writes horizon; write
//    only while the block is idle.
//  - One sample is in work at a time. Per sample: an accept in ST_IDLE, a
//    sweep of ring reads (one memory read port, one entry per cycle, over
//    the n entries of the active window), the multiply states ST_MUL_A,
//    ST_MUL_B and ST_MUL_C, then three passes of the shared iterative
//    divider over DVW = PW + 17 quotient bits each (81 at defaults), and the
//    move to the output register; a one-sample window skips the math.
//  - The result sits in an output register; a stalled receiver holds it and
//    the next finished result waits in ST_OUT until that beat is taken.
//  - Reset clears the fill count, write slot, registers to defaults and the
//    pipeline; ring contents are never cleared, since only written entries
//    are ever read.
module windowed_linear_trend_predictor_top #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [39:0]            rsp_prediction,
   output logic signed [39:0]            rsp_slope,
   output logic signed [39:0]            rsp_intercept,
   output logic                          rsp_fit_ok,
   input  logic                          csr_wr_en,
   input  logic [0:0]                    csr_index,
   input  logic [7:0]                    csr_wdata
);

   localparam int S    = SAMPLE_BITS;
   localparam int OW   = wltp_pkg::OUT_W;
   localparam int NB   = $clog2(MAX_WINDOW + 1);   // holds counts 0..MAX_WINDOW
   localparam int AW   = $clog2(MAX_WINDOW);       // ring address
   localparam int CW   = (NB > 7 ? NB : 7) + 1;    // compare width for n
   localparam int SYW  = S + NB + 1;
   localparam int SXYW = S + 2 * NB + 1;
   localparam int SXW  = 2 * NB + 1;
   localparam int SX2W = 3 * NB + 1;
   localparam int NW   = S + 4 * NB + 3;
   localparam int DW   = 4 * NB + 1;
   localparam int TW   = NB + 9;
   localparam int PW   = NW + TW + 1;
   localparam int QW   = PW + wltp_pkg::WIDE_SHIFT + 1;
   localparam int P1W  = NB + 1 + SXYW;
   localparam int P2W  = SXW + SYW;
   localparam int P3W  = SYW + SX2W;
   localparam int P4W  = SXW + SXYW;
   localparam int P5W  = NB + 1 + SX2W;
   localparam int P6W  = 2 * SXW;
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);
   localparam logic [NB-1:0] MAX_N     = NB'(MAX_WINDOW);
   localparam logic signed [QW-1:0] ONE_Q  = 1;
   localparam logic signed [QW-1:0] SAT_HI = {{(QW-OW+1){1'b0}}, {(OW-1){1'b1}}};
   localparam logic signed [QW-1:0] SAT_LO = {{(QW-OW+1){1'b1}}, {(OW-1){1'b0}}};

   // sample ring
   logic signed [S-1:0] ring [MAX_WINDOW];
   logic signed [S-1:0] rd_data_ff;

   wltp_pkg::state_type state_ff, state_in;

   logic [6:0]           wl_ff;
   logic [7:0]           hz_ff;
   logic [NB-1:0]        fill_ff, fill_in;
   logic [AW-1:0]        ws_ff, ws_in;
   logic [NB-1:0]        n_ff, n_in;
   logic [AW-1:0]        ptr_ff;
   logic [AW-1:0]        start_in;
   logic [NB-1:0]        iss_ff;
   logic [NB-1:0]        idx_ff;
   logic                 vld_ff;
   logic signed [S-1:0]  y_ff;

   logic signed [SYW-1:0]  sy_ff;
   logic signed [SXYW-1:0] sxy_ff;
   logic signed [SXW-1:0]  sx_ff;
   logic signed [SX2W-1:0] sx2_ff;

   logic signed [P1W-1:0] p1_ff;
   logic signed [P2W-1:0] p2_ff;
   logic signed [P3W-1:0] p3_ff;
   logic signed [P4W-1:0] p4_ff;
   logic signed [P5W-1:0] p5_ff;
   logic signed [P6W-1:0] p6_ff;
   logic signed [NW-1:0]  num_m_ff, num_b_ff;
   logic [DW-1:0]         d_ff;
   logic [TW-1:0]         t_ff;
   logic signed [PW-1:0]  pm_ff;

   logic signed [OW-1:0] pred_res_ff, slope_res_ff, icpt_res_ff;
   logic                 fit_res_ff;
   logic signed [OW-1:0] pred_out_ff, slope_out_ff, icpt_out_ff;
   logic                 fit_out_ff;
   logic                 rsp_valid_ff;

   logic                  accept;
   logic                  rd_en;
   logic                  out_free;
   logic                  sweep_end;
   logic [CW-1:0]         wl_x, fill_x;
   logic [AW:0]           ws_x;
   logic signed [NB:0]    ns;
   logic [2*NB-1:0]       sq;
   logic signed [NB+S:0]  ixv;
   logic signed [PW-1:0]  p_sum;
   logic signed [PW-1:0]  div_x;
   logic signed [QW-1:0]  div_qv;
   logic signed [QW-1:0]  rnd_sum, rnd;
   logic signed [OW-1:0]  rnd_sat;
   wltp_pkg::div_ctl_type div_ctl;
   wltp_pkg::div_sts_type div_sts;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rd_en    = (state_ff == wltp_pkg::ST_SWEEP) && (iss_ff != n_ff);
   assign sweep_end = (state_ff == wltp_pkg::ST_SWEEP) && (iss_ff == n_ff) && !vld_ff;

   // fill, write slot and active window length after this sample lands
   always_comb begin
      fill_in = (fill_ff == MAX_N) ? fill_ff : fill_ff + NB'(1);
      ws_in   = (ws_ff == LAST_SLOT) ? '0 : ws_ff + AW'(1);
      wl_x    = CW'(wl_ff);
      fill_x  = CW'(fill_in);
      if (wl_x == '0) begin
         wl_x = CW'(1);
      end
      if (wl_x > CW'(MAX_WINDOW)) begin
         wl_x = CW'(MAX_WINDOW);
      end
      n_in = (fill_x < wl_x) ? fill_in : NB'(wl_x);
      // oldest slot of the window, wrapping below zero
      ws_x = {1'b0, ws_in};
      if (ws_x >= (AW+1)'(n_in)) begin
         start_in = AW'(ws_x - (AW+1)'(n_in));
      end else begin
         start_in = AW'(ws_x + (AW+1)'(MAX_WINDOW) - (AW+1)'(n_in));
      end
   end

   always_comb begin
      ns      = $signed({1'b0, n_ff});
      sq      = idx_ff * idx_ff;
      ixv     = $signed({1'b0, idx_ff}) * rd_data_ff;
      p_sum   = pm_ff + PW'(num_b_ff);
   end

   // round half up from the extra quotient bit, then saturate
   always_comb begin
      rnd_sum = div_qv + ONE_Q;
      rnd     = rnd_sum >>> 1;
      if (rnd > SAT_HI) begin
         rnd_sat = SAT_HI[OW-1:0];
      end else if (rnd < SAT_LO) begin
         rnd_sat = SAT_LO[OW-1:0];
      end else begin
         rnd_sat = rnd[OW-1:0];
      end
   end

   always_comb begin
      state_in          = state_ff;
      div_ctl.start     = 1'b0;
      div_ctl.wide_frac = 1'b0;
      div_x             = p_sum;
      unique case (state_ff)
         wltp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = wltp_pkg::ST_SWEEP;
            end
         end
         wltp_pkg::ST_SWEEP: begin
            if (sweep_end) begin
               state_in = (n_ff < NB'(2)) ? wltp_pkg::ST_OUT : wltp_pkg::ST_MUL_A;
            end
         end
         wltp_pkg::ST_MUL_A: state_in = wltp_pkg::ST_MUL_B;
         wltp_pkg::ST_MUL_B: state_in = wltp_pkg::ST_MUL_C;
         wltp_pkg::ST_MUL_C: begin
            state_in          = wltp_pkg::ST_DIV_M;
            div_ctl.start     = 1'b1;
            div_ctl.wide_frac = 1'b1;
            div_x             = PW'(num_m_ff);
         end
         wltp_pkg::ST_DIV_M: begin
            div_x = PW'(num_b_ff);
            if (div_sts.done) begin
               state_in      = wltp_pkg::ST_DIV_B;
               div_ctl.start = 1'b1;
            end
         end
         wltp_pkg::ST_DIV_B: begin
            if (div_sts.done) begin
               state_in      = wltp_pkg::ST_DIV_P;
               div_ctl.start = 1'b1;
            end
         end
         wltp_pkg::ST_DIV_P: begin
            if (div_sts.done) begin
               state_in = wltp_pkg::ST_OUT;
            end
         end
         wltp_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = wltp_pkg::ST_IDLE;
            end
         end
         default: state_in = wltp_pkg::ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == wltp_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wltp_pkg::ST_IDLE;
         fill_ff      <= '0;
         ws_ff        <= '0;
         wl_ff        <= wltp_pkg::WL_RESET;
         hz_ff        <= wltp_pkg::HZ_RESET;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= rd_en;
         if (accept) begin
            fill_ff <= fill_in;
            ws_ff   <= ws_in;
         end
         if (csr_wr_en) begin
            unique case (wltp_pkg::csr_index_type'(csr_index))
               wltp_pkg::CSR_WINDOW_LENGTH: wl_ff <= csr_wdata[6:0];
               wltp_pkg::CSR_HORIZON:       hz_ff <= csr_wdata;
               default: ;
            endcase
         end
         // drop the beat once taken; load a new one when leaving ST_OUT
         if (state_ff == wltp_pkg::ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ring memory: write on accept, one registered read per sweep cycle while entries remain
   always_ff @(posedge clock) begin
      if (accept) begin
         ring[ws_ff] <= req_sample;
      end
      if (rd_en) begin
         rd_data_ff <= ring[ptr_ff];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff   <= n_in;
         ptr_ff <= start_in;
         iss_ff <= '0;
         y_ff   <= req_sample;
         sy_ff  <= '0;
         sxy_ff <= '0;
         sx_ff  <= '0;
         sx2_ff <= '0;
      end
      if (rd_en) begin
         iss_ff <= iss_ff + NB'(1);
         idx_ff <= iss_ff;
         ptr_ff <= (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + AW'(1);
      end
      if (vld_ff) begin
         sy_ff  <= sy_ff + SYW'(rd_data_ff);
         sxy_ff <= sxy_ff + SXYW'(ixv);
         sx_ff  <= sx_ff + SXW'($signed({1'b0, idx_ff}));
         sx2_ff <= sx2_ff + SX2W'($signed({1'b0, sq}));
      end
      if (sweep_end) begin
         // no-fit result, kept only for a single sample window; a fit overwrites it
         fit_res_ff   <= 1'b0;
         slope_res_ff <= '0;
         icpt_res_ff  <= '0;
         pred_res_ff  <= {{(OW-S-8){y_ff[S-1]}}, y_ff, 8'b0};
      end
      if (state_ff == wltp_pkg::ST_MUL_A) begin
         p1_ff      <= ns * sxy_ff;
         p2_ff      <= sx_ff * sy_ff;
         p3_ff      <= sy_ff * sx2_ff;
         p4_ff      <= sx_ff * sxy_ff;
         p5_ff      <= ns * sx2_ff;
         p6_ff      <= sx_ff * sx_ff;
         fit_res_ff <= 1'b1;
      end
      if (state_ff == wltp_pkg::ST_MUL_B) begin
         num_m_ff <= NW'(p1_ff) - NW'(p2_ff);
         num_b_ff <= NW'(p3_ff) - NW'(p4_ff);
         d_ff     <= DW'(p5_ff - P5W'(p6_ff));
         t_ff     <= TW'(n_ff) - TW'(1) + TW'(hz_ff);
      end
      if (state_ff == wltp_pkg::ST_MUL_C) begin
         pm_ff <= num_m_ff * $signed({1'b0, t_ff});
      end
      if (div_sts.done) begin
         priority case (state_ff)
            wltp_pkg::ST_DIV_M: slope_res_ff <= rnd_sat;
            wltp_pkg::ST_DIV_B: icpt_res_ff  <= rnd_sat;
            default:            pred_res_ff  <= rnd_sat;
         endcase
      end
      if (state_ff == wltp_pkg::ST_OUT && out_free) begin
         pred_out_ff  <= pred_res_ff;
         slope_out_ff <= slope_res_ff;
         icpt_out_ff  <= icpt_res_ff;
         fit_out_ff   <= fit_res_ff;
      end
   end

   wltp_div #(
      .XW (PW),
      .DW (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_x),
      .divisor  (d_ff),
      .sts      (div_sts),
      .quotient (div_qv)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = pred_out_ff;
   assign rsp_slope      = slope_out_ff;
   assign rsp_intercept  = icpt_out_ff;
   assign rsp_fit_ok     = fit_out_ff;

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MAX_N)
      else $error("fill count above window capacity");
   a_no_fit_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fit_ok |-> rsp_slope == '0 && rsp_intercept == '0)
      else $error("unfitted result carries a line");
   a_div_start_free : assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_sts.busy)
      else $error("divider started while busy");
   a_window_le_fill : assert property (@(posedge clock) disable iff (reset)
      state_ff == wltp_pkg::ST_SWEEP |-> n_ff <= fill_ff && n_ff != '0)
      else $error("window longer than stored samples");

endmodule

// File: rtl/wltp_div.sv
// Iterative restoring divider: floor(dividend * 2^shift / divisor), divisor > 0.
// Depends on wltp_pkg (control/status structs, shift constants).
module wltp_div #(
   parameter int XW = 64,
   parameter int DW = 29,
   localparam int DVW = XW + wltp_pkg::WIDE_SHIFT,
   localparam int QW = DVW + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wltp_pkg::div_ctl_type   ctl,
   input  logic signed [XW-1:0]    dividend,
   input  logic [DW-1:0]           divisor,
   output wltp_pkg::div_sts_type   sts,
   output logic signed [QW-1:0]    quotient
);

   localparam int CW = $clog2(DVW + 1);
   localparam int PADW = wltp_pkg::WIDE_SHIFT - wltp_pkg::NARROW_SHIFT;

   logic [CW-1:0]       cnt_ff;
   logic [DVW-1:0]      dvd_ff;
   logic [DW-1:0]       rem_ff;
   logic [DW-1:0]       d_ff;
   logic                neg_ff;
   logic                busy_ff;
   logic                fin_ff;
   logic                done_ff;
   logic signed [QW-1:0] q_ff;

   logic [XW-1:0]       mag;
   logic [DW:0]         trial;
   logic                ge;
   logic signed [QW-1:0] q_pos;

   always_comb begin
      mag   = dividend[XW-1] ? XW'(-dividend) : XW'(dividend);
      trial = {rem_ff, dvd_ff[DVW-1]};
      ge    = trial >= {1'b0, d_ff};
      q_pos = $signed({1'b0, dvd_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         cnt_ff <= CW'(DVW);
         rem_ff <= '0;
         d_ff   <= divisor;
         neg_ff <= dividend[XW-1];
         if (ctl.wide_frac) begin
            dvd_ff <= {mag, {wltp_pkg::WIDE_SHIFT{1'b0}}};
         end else begin
            dvd_ff <= {{PADW{1'b0}}, mag, {wltp_pkg::NARROW_SHIFT{1'b0}}};
         end
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         rem_ff <= ge ? DW'(trial - {1'b0, d_ff}) : trial[DW-1:0];
         dvd_ff <= {dvd_ff[DVW-2:0], ge};
      end
      // apply sign with floor rounding toward minus infinity
      if (fin_ff) begin
         q_ff <= neg_ff ? (-q_pos - QW'($signed({1'b0, rem_ff != '0}))) : q_pos;
      end
   end

   assign sts.busy = busy_ff | fin_ff;
   assign sts.done = done_ff;
   assign quotient = q_ff;

   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < d_ff)
      else $error("divider remainder reached divisor");
   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");
   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff && !fin_ff)
      else $error("divider started while busy");

endmodule
